[rtl/core/tkbf_pkg.sv]
package tkbf_pkg;

    localparam int DEFAULT_LIST_DEPTH = 8;

    localparam int SCORE_W = 16;
    localparam int DIST_W  = 16;
    localparam int MODEL_W = 8;
    localparam int LOC_W   = 16;
    localparam int COUNT_W = 4;
    localparam int RANK_W  = 3;

    typedef struct packed {
        logic [SCORE_W-1:0]        score;
        logic [DIST_W-1:0]         peak_dist;
        logic [MODEL_W-1:0]        model;
        logic signed [LOC_W-1:0]   x;
        logic signed [LOC_W-1:0]   y;
        logic signed [LOC_W-1:0]   z;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_cand;
        logic do_insert;
    } cmd_t;

endpackage

[rtl/core/tkbf_ctrl.sv]
module tkbf_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    output tkbf_pkg::cmd_t  cmd
);

    tkbf_pkg::state_t state_reg;
    tkbf_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tkbf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tkbf_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = tkbf_pkg::ST_INSERT;
                end
            end
            tkbf_pkg::ST_INSERT:
            begin
                state_next = tkbf_pkg::ST_DONE;
            end
            tkbf_pkg::ST_DONE:
            begin
                if (!out_stall)
                begin
                    state_next = tkbf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tkbf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall      = 1'b1;
        out_valid     = 1'b0;
        cmd.load_cand = 1'b0;
        cmd.do_insert = 1'b0;
        unique case (state_reg)
            tkbf_pkg::ST_IDLE:
            begin
                in_stall      = 1'b0;
                cmd.load_cand = in_valid;
            end
            tkbf_pkg::ST_INSERT:
            begin
                cmd.do_insert = 1'b1;
            end
            tkbf_pkg::ST_DONE:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

[rtl/core/tkbf_datapath.sv]
module tkbf_datapath
#(
    parameter int LIST_DEPTH = tkbf_pkg::DEFAULT_LIST_DEPTH
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tkbf_pkg::cmd_t                       cmd,
    input  logic [tkbf_pkg::SCORE_W-1:0]         score,
    input  logic [tkbf_pkg::DIST_W-1:0]          peak_dist,
    input  logic [tkbf_pkg::MODEL_W-1:0]         model_idx,
    input  logic signed [tkbf_pkg::LOC_W-1:0]    loc_x,
    input  logic signed [tkbf_pkg::LOC_W-1:0]    loc_y,
    input  logic signed [tkbf_pkg::LOC_W-1:0]    loc_z,
    output logic [tkbf_pkg::SCORE_W-1:0]         best_score,
    output logic [tkbf_pkg::DIST_W-1:0]          best_peak_dist,
    output logic [tkbf_pkg::MODEL_W-1:0]         best_model,
    output logic signed [tkbf_pkg::LOC_W-1:0]    best_x,
    output logic signed [tkbf_pkg::LOC_W-1:0]    best_y,
    output logic signed [tkbf_pkg::LOC_W-1:0]    best_z,
    output logic [tkbf_pkg::COUNT_W-1:0]         kept_count,
    output logic                                 accepted,
    output logic [tkbf_pkg::RANK_W-1:0]          insert_rank
);

    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int RW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    tkbf_pkg::entry_t cand_reg;
    tkbf_pkg::entry_t entries_reg  [LIST_DEPTH];
    tkbf_pkg::entry_t entries_next [LIST_DEPTH];
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    tkbf_pkg::entry_t res_entry_reg;
    logic [CW-1:0]    res_count_reg;
    logic             res_take_reg;
    logic [RW-1:0]    res_rank_reg;

    logic [LIST_DEPTH-1:0] le;
    logic [LIST_DEPTH-1:0] ins;
    logic                  full;
    logic                  take;
    logic [RW-1:0]         rank_enc;
    logic [CW+3:0]         count_wide;
    logic [RW+2:0]         rank_wide;

    always_ff @(posedge clk)
    begin
        if (cmd.load_cand)
        begin
            cand_reg.score     <= score;
            cand_reg.peak_dist <= peak_dist;
            cand_reg.model     <= model_idx;
            cand_reg.x         <= loc_x;
            cand_reg.y         <= loc_y;
            cand_reg.z         <= loc_z;
        end
    end

    assign full = (count_reg == CW'(LIST_DEPTH));
    assign take = !full || (cand_reg.score < entries_reg[LIST_DEPTH-1].score);

    // Kept scores are ascending, so le is a run of ones from rank zero;
    // the candidate lands on the first cell whose le is clear.
    for (genvar i = 0; i < LIST_DEPTH; i++)
    begin : g_cell
        assign le[i] = (CW'(i) < count_reg) && (entries_reg[i].score <= cand_reg.score);

        if (i == 0)
        begin : g_head
            assign ins[i] = !le[i];

            always_comb
            begin
                entries_next[i] = entries_reg[i];
                if (cmd.do_insert && take && !le[i])
                begin
                    entries_next[i] = cand_reg;
                end
            end
        end
        else
        begin : g_body
            assign ins[i] = !le[i] && le[i-1];

            always_comb
            begin
                entries_next[i] = entries_reg[i];
                if (cmd.do_insert && take && !le[i])
                begin
                    entries_next[i] = ins[i] ? cand_reg : entries_reg[i-1];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            entries_reg[i] <= entries_next[i];
        end
    end

    always_comb
    begin
        rank_enc = '0;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            if (ins[i])
            begin
                rank_enc = rank_enc | RW'(i);
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.do_insert && take && !full)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Capture the result alongside the list update.
    always_ff @(posedge clk)
    begin
        if (cmd.do_insert)
        begin
            res_entry_reg <= (take && ins[0]) ? cand_reg : entries_reg[0];
            res_count_reg <= count_next;
            res_take_reg  <= take;
            res_rank_reg  <= take ? rank_enc : '0;
        end
    end

    assign count_wide = {4'b0, res_count_reg};
    assign rank_wide  = {3'b0, res_rank_reg};

    assign best_score     = res_entry_reg.score;
    assign best_peak_dist = res_entry_reg.peak_dist;
    assign best_model     = res_entry_reg.model;
    assign best_x         = res_entry_reg.x;
    assign best_y         = res_entry_reg.y;
    assign best_z         = res_entry_reg.z;
    assign kept_count     = count_wide[3:0];
    assign accepted       = res_take_reg;
    assign insert_rank    = rank_wide[2:0];

endmodule

[rtl/core/top_k_best_fit_keeper.sv]
// Keeps the LIST_DEPTH lowest-score candidate fits in ascending order, equal
// scores in arrival order. For each item the candidate is first captured, then
// every list cell compares against it and shifts or loads in parallel, then the
// result (rank zero entry, count, accepted flag and insert rank) is presented.
// The block takes one item at a time, so a stall on the output holds off the
// next item. Once the list is full, a candidate is kept only if its score is
// strictly below the worst kept score; the worst entry then drops off.
module top_k_best_fit_keeper
#(
    parameter int LIST_DEPTH = tkbf_pkg::DEFAULT_LIST_DEPTH
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [tkbf_pkg::SCORE_W-1:0]         score,
    input  logic [tkbf_pkg::DIST_W-1:0]          peak_dist,
    input  logic [tkbf_pkg::MODEL_W-1:0]         model_idx,
    input  logic signed [tkbf_pkg::LOC_W-1:0]    loc_x,
    input  logic signed [tkbf_pkg::LOC_W-1:0]    loc_y,
    input  logic signed [tkbf_pkg::LOC_W-1:0]    loc_z,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [tkbf_pkg::SCORE_W-1:0]         best_score,
    output logic [tkbf_pkg::DIST_W-1:0]          best_peak_dist,
    output logic [tkbf_pkg::MODEL_W-1:0]         best_model,
    output logic signed [tkbf_pkg::LOC_W-1:0]    best_x,
    output logic signed [tkbf_pkg::LOC_W-1:0]    best_y,
    output logic signed [tkbf_pkg::LOC_W-1:0]    best_z,
    output logic [tkbf_pkg::COUNT_W-1:0]         kept_count,
    output logic                                 accepted,
    output logic [tkbf_pkg::RANK_W-1:0]          insert_rank
);

    tkbf_pkg::cmd_t cmd;

    tkbf_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    tkbf_datapath
    #(
        .LIST_DEPTH (LIST_DEPTH)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .score          (score),
        .peak_dist      (peak_dist),
        .model_idx      (model_idx),
        .loc_x          (loc_x),
        .loc_y          (loc_y),
        .loc_z          (loc_z),
        .best_score     (best_score),
        .best_peak_dist (best_peak_dist),
        .best_model     (best_model),
        .best_x         (best_x),
        .best_y         (best_y),
        .best_z         (best_z),
        .kept_count     (kept_count),
        .accepted       (accepted),
        .insert_rank    (insert_rank)
    );

endmodule
